// ===== hw/rtl/psde_pkg.sv =====
// ----------------------------------------------------------------------------
// psde_pkg
// Shared constants and the byte-wise CRC-32 step of the PNG writer.
// ----------------------------------------------------------------------------
package psde_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned DIM_W       = 15;
	localparam int unsigned CFG_W       = 13;
	localparam int unsigned ROW_W       = 17;

	localparam logic [15:0] BLOCK_BYTES = 16'hFFFF;
	localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
	localparam logic [16:0] ADLER_MOD   = 17'd65521;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/psde_queue.sv =====
// ----------------------------------------------------------------------------
// psde_queue
// Front end: accepts pixel bytes and holds them for the file sequencer.
// ----------------------------------------------------------------------------
module psde_queue (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_data,
	output logic       out_valid,
	input  logic       out_pop,
	output logic [7:0] out_data
);

	localparam int unsigned AW = $clog2(psde_pkg::QUEUE_DEPTH);

	logic [7:0]  mem_q [psde_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic push, pop;

	assign in_ready  = (cnt_q != (AW+1)'(psde_pkg::QUEUE_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_pop && out_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (AW+1)'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/psde_back.sv =====
// ----------------------------------------------------------------------------
// psde_back
// Back end: sequences the PNG file bytes, CRC-32, Adler-32 and stored blocks.
// ----------------------------------------------------------------------------
module psde_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [psde_pkg::DIM_W-1:0]  frame_w,
	input  logic [psde_pkg::DIM_W-1:0]  frame_h,
	input  logic                        q_valid,
	input  logic [7:0]                  q_data,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  out_data,
	output logic                        out_last
);

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_BLK, S_LEN, S_HEAD, S_BHDR, S_RAW, S_TAIL
	} state_t;

	state_t state_q;
	logic [5:0]  idx_q;
	logic [psde_pkg::DIM_W-1:0] fw_q, fh_q;
	logic [31:0] raw_total_q, idat_len_q, raw_pos_q, crc_q;
	logic [16:0] blocks_q;
	logic [15:0] adl_lo_q, adl_hi_q, fill_q;
	logic [psde_pkg::ROW_W-1:0] row_col_q;
	logic [7:0]  out_data_q;
	logic        out_last_q, out_valid_q;

	logic        en, fire, upd_crc, init_crc, last_byte, is_filter;
	logic [7:0]  byte_v;
	logic [31:0] crc_fin, left, y, adler;
	logic [15:0] take;
	logic [16:0] s_sum, blocks_n, lo_sum, lo_n, hi_sum, hi_n;
	logic [psde_pkg::ROW_W-1:0] row_len;

	assign en       = !out_valid_q || out_ready;
	assign crc_fin  = ~crc_q;
	assign left     = raw_total_q - raw_pos_q;
	assign take     = (left > 32'd65535) ? 16'hFFFF : left[15:0];
	assign row_len  = {fw_q, 2'b00} + psde_pkg::ROW_W'(1);
	assign is_filter = (row_col_q == '0);
	assign adler    = {adl_hi_q, adl_lo_q};

	assign y        = raw_total_q + {16'd0, psde_pkg::BLOCK_BYTES - 16'd1};
	assign s_sum    = {1'b0, y[31:16]} + {1'b0, y[15:0]};
	assign blocks_n = {1'b0, y[31:16]} + ((s_sum >= 17'd65535) ? 17'd1 : 17'd0);

	assign lo_sum = {1'b0, adl_lo_q} + {9'd0, byte_v};
	assign lo_n   = (lo_sum >= psde_pkg::ADLER_MOD) ? lo_sum - psde_pkg::ADLER_MOD : lo_sum;
	assign hi_sum = {1'b0, adl_hi_q} + lo_n;
	assign hi_n   = (hi_sum >= psde_pkg::ADLER_MOD) ? hi_sum - psde_pkg::ADLER_MOD : hi_sum;

	always_comb begin
		byte_v    = 8'd0;
		upd_crc   = 1'b0;
		init_crc  = 1'b0;
		last_byte = 1'b0;
		fire      = 1'b0;
		q_pop     = 1'b0;
		case (state_q)
			S_HEAD: begin
				fire = en;
				upd_crc = 1'b1;
				case (idx_q)
					6'd0: begin byte_v = 8'd137; upd_crc = 1'b0; end
					6'd1: begin byte_v = 8'd80;  upd_crc = 1'b0; end
					6'd2: begin byte_v = 8'd78;  upd_crc = 1'b0; end
					6'd3: begin byte_v = 8'd71;  upd_crc = 1'b0; end
					6'd4: begin byte_v = 8'd13;  upd_crc = 1'b0; end
					6'd5: begin byte_v = 8'd10;  upd_crc = 1'b0; end
					6'd6: begin byte_v = 8'd26;  upd_crc = 1'b0; end
					6'd7: begin byte_v = 8'd10;  upd_crc = 1'b0; end
					6'd8, 6'd9, 6'd10: upd_crc = 1'b0;
					6'd11: begin byte_v = 8'd13; upd_crc = 1'b0; init_crc = 1'b1; end
					6'd12: byte_v = 8'h49;
					6'd13: byte_v = 8'h48;
					6'd14: byte_v = 8'h44;
					6'd15: byte_v = 8'h52;
					6'd16, 6'd17: byte_v = 8'd0;
					6'd18: byte_v = {1'b0, fw_q[14:8]};
					6'd19: byte_v = fw_q[7:0];
					6'd20, 6'd21: byte_v = 8'd0;
					6'd22: byte_v = {1'b0, fh_q[14:8]};
					6'd23: byte_v = fh_q[7:0];
					6'd24: byte_v = 8'd8;
					6'd25: byte_v = 8'd6;
					6'd26, 6'd27, 6'd28: byte_v = 8'd0;
					6'd29: begin byte_v = crc_fin[31:24]; upd_crc = 1'b0; end
					6'd30: begin byte_v = crc_fin[23:16]; upd_crc = 1'b0; end
					6'd31: begin byte_v = crc_fin[15:8];  upd_crc = 1'b0; end
					6'd32: begin byte_v = crc_fin[7:0];   upd_crc = 1'b0; end
					6'd33: begin byte_v = idat_len_q[31:24]; upd_crc = 1'b0; end
					6'd34: begin byte_v = idat_len_q[23:16]; upd_crc = 1'b0; end
					6'd35: begin byte_v = idat_len_q[15:8];  upd_crc = 1'b0; end
					6'd36: begin
						byte_v = idat_len_q[7:0]; upd_crc = 1'b0; init_crc = 1'b1;
					end
					6'd37: byte_v = 8'h49;
					6'd38: byte_v = 8'h44;
					6'd39: byte_v = 8'h41;
					6'd40: byte_v = 8'h54;
					6'd41: byte_v = 8'h78;
					default: byte_v = 8'h01;
				endcase
			end
			S_BHDR: begin
				fire = en && q_valid;
				upd_crc = 1'b1;
				case (idx_q)
					6'd0: byte_v = (left <= 32'd65535) ? 8'd1 : 8'd0;
					6'd1: byte_v = take[7:0];
					6'd2: byte_v = take[15:8];
					6'd3: byte_v = ~take[7:0];
					default: byte_v = ~take[15:8];
				endcase
			end
			S_RAW: begin
				upd_crc = 1'b1;
				byte_v  = is_filter ? 8'd0 : q_data;
				fire    = en && q_valid;
				q_pop   = en && !is_filter;
			end
			S_TAIL: begin
				fire = en;
				case (idx_q)
					6'd0: begin byte_v = adler[31:24]; upd_crc = 1'b1; end
					6'd1: begin byte_v = adler[23:16]; upd_crc = 1'b1; end
					6'd2: begin byte_v = adler[15:8];  upd_crc = 1'b1; end
					6'd3: begin byte_v = adler[7:0];   upd_crc = 1'b1; end
					6'd4, 6'd16: byte_v = crc_fin[31:24];
					6'd5, 6'd17: byte_v = crc_fin[23:16];
					6'd6, 6'd18: byte_v = crc_fin[15:8];
					6'd7: byte_v = crc_fin[7:0];
					6'd8, 6'd9, 6'd10: byte_v = 8'd0;
					6'd11: init_crc = 1'b1;
					6'd12: begin byte_v = 8'h49; upd_crc = 1'b1; end
					6'd13: begin byte_v = 8'h45; upd_crc = 1'b1; end
					6'd14: begin byte_v = 8'h4E; upd_crc = 1'b1; end
					6'd15: begin byte_v = 8'h44; upd_crc = 1'b1; end
					default: begin byte_v = crc_fin[7:0]; last_byte = 1'b1; end
				endcase
			end
			default: fire = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_data_q  <= '0;
			crc_q       <= '1;
			adl_lo_q    <= 16'd1;
			adl_hi_q    <= '0;
			raw_pos_q   <= '0;
			row_col_q   <= '0;
			fill_q      <= '0;
			fw_q        <= '0;
			fh_q        <= '0;
			raw_total_q <= '0;
			blocks_q    <= '0;
			idat_len_q  <= '0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				out_data_q  <= byte_v;
				out_last_q  <= last_byte;
				if (init_crc) begin
					crc_q <= '1;
				end else if (upd_crc) begin
					crc_q <= psde_pkg::crc_byte(crc_q, byte_v);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						fw_q    <= frame_w;
						fh_q    <= frame_h;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					raw_total_q <= {15'd0, row_len} * {17'd0, fh_q};
					state_q     <= S_BLK;
				end
				S_BLK: begin
					blocks_q <= blocks_n;
					state_q  <= S_LEN;
				end
				S_LEN: begin
					idat_len_q <= raw_total_q + 32'd6 + {13'd0, blocks_q, 2'b00}
						+ {15'd0, blocks_q};
					adl_lo_q  <= 16'd1;
					adl_hi_q  <= '0;
					raw_pos_q <= '0;
					row_col_q <= '0;
					fill_q    <= '0;
					idx_q     <= '0;
					state_q   <= S_HEAD;
				end
				S_HEAD: begin
					if (fire) begin
						if (idx_q == 6'd42) begin
							idx_q   <= '0;
							state_q <= S_BHDR;
						end else begin
							idx_q <= idx_q + 6'd1;
						end
					end
				end
				S_BHDR: begin
					if (fire) begin
						if (idx_q == 6'd4) begin
							idx_q   <= '0;
							state_q <= S_RAW;
						end else begin
							idx_q <= idx_q + 6'd1;
						end
					end
				end
				S_RAW: begin
					if (fire) begin
						adl_lo_q  <= lo_n[15:0];
						adl_hi_q  <= hi_n[15:0];
						raw_pos_q <= raw_pos_q + 32'd1;
						row_col_q <= (row_col_q + psde_pkg::ROW_W'(1) >= row_len) ? '0
							: row_col_q + psde_pkg::ROW_W'(1);
						if (fill_q + 16'd1 >= psde_pkg::BLOCK_BYTES) begin
							fill_q <= '0;
						end else begin
							fill_q <= fill_q + 16'd1;
						end
						if (raw_pos_q + 32'd1 == raw_total_q) begin
							idx_q   <= '0;
							state_q <= S_TAIL;
						end else if (fill_q + 16'd1 >= psde_pkg::BLOCK_BYTES) begin
							idx_q   <= '0;
							state_q <= S_BHDR;
						end
					end
				end
				S_TAIL: begin
					if (fire) begin
						if (idx_q == 6'd19) begin
							idx_q     <= '0;
							raw_pos_q <= '0;
							row_col_q <= '0;
							fill_q    <= '0;
							state_q   <= S_IDLE;
						end else begin
							idx_q <= idx_q + 6'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_last  = out_last_q;

endmodule

// ===== hw/rtl/png_stored_deflate_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// png_stored_deflate_encoder_unit
// Streams an RGBA8 image in and a complete PNG file with stored deflate out.
// ----------------------------------------------------------------------------
// Pixel bytes enter through a four-entry queue; the file sequencer behind it
// emits one file byte per cycle while the output is ready and, in block
// headers and image data, a pixel byte is queued. Each row gets a filter
// byte, each stored block a five-byte header. A frame's first byte starts
// the size setup (sample, multiply, block count, length), then 43 header
// bytes; 20 trailer bytes follow its last. Size is sampled when a frame opens.
module png_stored_deflate_encoder_unit #(
	parameter int unsigned MAX_WIDTH  = 4096,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,  // [7:0] pixel_byte
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [7:0]                  m_axis_tdata,  // [7:0] file_byte
	output logic                        m_axis_tlast,
	input  logic                        cfg_wen,
	input  logic [1:0]                  cfg_addr,
	input  logic [psde_pkg::CFG_W-1:0]  cfg_wdata
);

	logic [psde_pkg::CFG_W-1:0] width_q, height_q;
	logic [psde_pkg::DIM_W-1:0] frame_w, frame_h;
	logic       q_valid, q_pop;
	logic [7:0] q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= psde_pkg::CFG_W'(1);
			height_q <= psde_pkg::CFG_W'(1);
		end else if (cfg_wen) begin
			case (cfg_addr)
				psde_pkg::REG_WIDTH:  width_q  <= cfg_wdata;
				psde_pkg::REG_HEIGHT: height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			frame_w = psde_pkg::DIM_W'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			frame_w = psde_pkg::DIM_W'(MAX_WIDTH);
		end else begin
			frame_w = psde_pkg::DIM_W'(width_q);
		end
		if (height_q == '0) begin
			frame_h = psde_pkg::DIM_W'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			frame_h = psde_pkg::DIM_W'(MAX_HEIGHT);
		end else begin
			frame_h = psde_pkg::DIM_W'(height_q);
		end
	end

	psde_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.out_valid (q_valid),
		.out_pop   (q_pop),
		.out_data  (q_data)
	);

	psde_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame_w   (frame_w),
		.frame_h   (frame_h),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
